### src/kbt_pkg.sv
// ----------------------------------------------------------------------------
// kbt_pkg
// Shared types, constants and helpers for the keyboard event tracker.
// ----------------------------------------------------------------------------
package kbt_pkg;

  localparam int KEY_COUNT  = 256;
  localparam int KEY_AW     = $clog2(KEY_COUNT);
  localparam int RING_DEPTH = 16;
  localparam int RING_AW    = $clog2(RING_DEPTH);

  // Operation codes carried in the request.
  localparam logic [2:0] FUNC_PRESS     = 3'd0;
  localparam logic [2:0] FUNC_RELEASE   = 3'd1;
  localparam logic [2:0] FUNC_POP       = 3'd2;
  localparam logic [2:0] FUNC_READ_HELD = 3'd3;
  localparam logic [2:0] FUNC_READ_DOWN = 3'd4;
  localparam logic [2:0] FUNC_READ_UP   = 3'd5;
  localparam logic [2:0] FUNC_FLUSH     = 3'd6;

  localparam logic [7:0] NO_BUFFER_CODE = 8'hAA;
  localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

  // Modifier scan codes: left/right shift, left/right alt, left/right ctrl.
  localparam int MOD_COUNT = 6;
  localparam logic [7:0] MOD_CODES [0:MOD_COUNT-1] = '{
    8'h2A, 8'h36, 8'h38, 8'hB8, 8'h1D, 8'h9D
  };

  typedef struct packed {
    logic [2:0]         func;
    logic [7:0]         scan_code;
    logic signed [31:0] now_time;
  } kbt_req_t;

  typedef struct packed {
    logic               key_valid;
    logic [10:0]        key_word;
    logic signed [31:0] key_time;
    logic [15:0]        event_count;
    logic signed [31:0] held_time;
    logic               key_pending;
  } kbt_rsp_t;

  typedef struct packed {
    logic        pressed;
    logic [31:0] went_down;
    logic [31:0] accum;
    logic [15:0] down_count;
    logic [15:0] up_count;
  } key_entry_t;

  typedef struct packed {
    logic              en;
    logic [KEY_AW-1:0] addr;
    key_entry_t        entry;
  } key_wr_t;

  typedef struct packed {
    logic [10:0] word;
    logic [31:0] stamp;
  } ring_entry_t;

  typedef struct packed {
    logic        push;
    logic        pop;
    logic        clear;
    ring_entry_t entry;
  } ring_ctl_t;

  function automatic logic [RING_AW-1:0] ring_next(input logic [RING_AW-1:0] p);
    logic [RING_AW-1:0] r;
    if (p == RING_AW'(RING_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    logic [15:0] r;
    if (v == COUNT_MAX) begin
      r = v;
    end else begin
      r = v + 16'd1;
    end
    return r;
  endfunction

endpackage

### src/kbt_key_table.sv
// ----------------------------------------------------------------------------
// kbt_key_table
// Per-key state memory with a registered read. Valid bits and a flush
// timestamp give reset and flush their effect without a clearing pass.
// ----------------------------------------------------------------------------
module kbt_key_table
  import kbt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [KEY_AW-1:0] rd_addr,
  output key_entry_t        rd_entry,
  input  key_wr_t           wr,
  input  logic              flush,
  input  logic [31:0]       flush_time
);

  key_entry_t            mem [0:KEY_COUNT-1];
  logic [KEY_COUNT-1:0]  valid;
  logic [31:0]           base_time;
  key_entry_t            rd_data;
  logic                  rd_hit;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.entry;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      base_time <= '0;
      rd_hit    <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_hit <= valid[rd_addr];
      end
      if (flush) begin
        valid     <= '0;
        base_time <= flush_time;
      end else if (wr.en) begin
        valid[wr.addr] <= 1'b1;
      end
    end
  end

  // An entry untouched since reset or the last flush reads as cleared, with
  // the went-down time equal to the last flush time, or zero after reset.
  always_comb begin
    if (rd_hit) begin
      rd_entry = rd_data;
    end else begin
      rd_entry            = '0;
      rd_entry.went_down  = base_time;
    end
  end

endmodule

### src/kbt_ring.sv
// ----------------------------------------------------------------------------
// kbt_ring
// Keycode ring buffer: a small memory with head and tail pointers. One slot
// stays empty, so the ring holds one entry fewer than its depth.
// ----------------------------------------------------------------------------
module kbt_ring
  import kbt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        rd_en,
  output ring_entry_t rd_entry,
  input  ring_ctl_t   ctl,
  output logic        empty,
  output logic        pending_next
);

  ring_entry_t        mem [0:RING_DEPTH-1];
  logic [RING_AW-1:0] head;
  logic [RING_AW-1:0] tail;
  logic [RING_AW-1:0] head_next;
  logic [RING_AW-1:0] tail_next;
  logic               full;
  logic               do_push;

  assign empty   = (head == tail);
  assign full    = (ring_next(tail) == head);
  assign do_push = ctl.push && !full && !ctl.clear;

  always_comb begin
    head_next = head;
    tail_next = tail;
    if (ctl.clear) begin
      head_next = '0;
      tail_next = '0;
    end else begin
      if (ctl.pop && !empty) begin
        head_next = ring_next(head);
      end
      if (do_push) begin
        tail_next = ring_next(tail);
      end
    end
  end

  assign pending_next = (head_next != tail_next);

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[tail] <= ctl.entry;
    end
    if (rd_en) begin
      rd_entry <= mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
    end else begin
      head <= head_next;
      tail <= tail_next;
    end
  end

endmodule

### src/keyboard_event_tracker.sv
// ----------------------------------------------------------------------------
// keyboard_event_tracker
// Keyboard scan-code buffer with per-key state (pressed, down time, held
// time, down and up counts) and a keycode ring with modifier flags.
//
//   Channel   Ports                       Direction  Handshake
//   request   start, busy, req            in         start && !busy
//   result    done, result                out        done, one cycle, no stall
//   config    cfg_write, cfg_data         in         cfg_write
//
// On each request the accept edge reads the key table and the ring slot at
// the head, the next cycle modifies and writes back, and the result appears
// with done in the cycle after that. busy is high during the write-back
// cycle. Flush takes the same path. Reset is synchronous and needs no
// clearing pass. The receiver cannot stall.
// ----------------------------------------------------------------------------
module keyboard_event_tracker
  import kbt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  kbt_req_t req,
  output logic     done,
  output kbt_rsp_t result,
  input  logic     cfg_write,
  input  logic     cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t               state;
  kbt_req_t             req_r;
  logic                 repeat_enable;
  logic [MOD_COUNT-1:0] mod_pressed;
  logic [MOD_COUNT-1:0] mod_next;
  logic                 accept;
  logic                 exec;

  key_entry_t  key_rd;
  key_entry_t  entry_next;
  key_wr_t     key_wr;
  logic        table_clear;
  ring_entry_t ring_rd;
  ring_ctl_t   ring_ctl;
  logic        ring_empty;
  logic        ring_pending_next;
  kbt_rsp_t    rsp_next;
  logic        push;
  logic [2:0]  flags;

  assign busy   = (state == ST_EXEC);
  assign accept = start && !busy;
  assign exec   = (state == ST_EXEC);

  kbt_key_table u_key_table (
    .clk        (clk),
    .rst        (rst),
    .rd_en      (accept),
    .rd_addr    (req.scan_code),
    .rd_entry   (key_rd),
    .wr         (key_wr),
    .flush      (table_clear),
    .flush_time (req_r.now_time)
  );

  kbt_ring u_ring (
    .clk          (clk),
    .rst          (rst),
    .rd_en        (accept),
    .rd_entry     (ring_rd),
    .ctl          (ring_ctl),
    .empty        (ring_empty),
    .pending_next (ring_pending_next)
  );

  always_comb begin
    entry_next  = key_rd;
    key_wr      = '0;
    table_clear = 1'b0;
    ring_ctl    = '0;
    rsp_next    = '0;
    mod_next    = mod_pressed;
    push        = 1'b0;
    key_wr.addr = req_r.scan_code;

    if (exec) begin
      case (req_r.func)
        FUNC_PRESS: begin
          if (!key_rd.pressed) begin
            entry_next.pressed    = 1'b1;
            entry_next.went_down  = req_r.now_time;
            entry_next.down_count = sat_inc(key_rd.down_count);
            key_wr.en             = 1'b1;
          end
          push = (!key_rd.pressed || repeat_enable) && (req_r.scan_code != NO_BUFFER_CODE);
          for (int i = 0; i < MOD_COUNT; i++) begin
            if (req_r.scan_code == MOD_CODES[i]) begin
              mod_next[i] = 1'b1;
            end
          end
        end
        FUNC_RELEASE: begin
          entry_next.pressed  = 1'b0;
          entry_next.up_count = sat_inc(key_rd.up_count);
          entry_next.accum    = key_rd.accum + (req_r.now_time - key_rd.went_down);
          key_wr.en           = 1'b1;
          for (int i = 0; i < MOD_COUNT; i++) begin
            if (req_r.scan_code == MOD_CODES[i]) begin
              mod_next[i] = 1'b0;
            end
          end
        end
        FUNC_POP: begin
          ring_ctl.pop = 1'b1;
          if (!ring_empty) begin
            rsp_next.key_valid = 1'b1;
            rsp_next.key_word  = ring_rd.word;
            rsp_next.key_time  = ring_rd.stamp;
          end
        end
        FUNC_READ_HELD: begin
          if (!key_rd.pressed) begin
            rsp_next.held_time = key_rd.accum;
            entry_next.accum   = '0;
          end else begin
            rsp_next.held_time   = req_r.now_time - key_rd.went_down;
            entry_next.went_down = req_r.now_time;
          end
          key_wr.en = 1'b1;
        end
        FUNC_READ_DOWN: begin
          rsp_next.event_count  = key_rd.down_count;
          entry_next.down_count = '0;
          key_wr.en             = 1'b1;
        end
        FUNC_READ_UP: begin
          rsp_next.event_count = key_rd.up_count;
          entry_next.up_count  = '0;
          key_wr.en            = 1'b1;
        end
        FUNC_FLUSH: begin
          ring_ctl.clear = 1'b1;
          table_clear    = 1'b1;
          mod_next       = '0;
        end
        default: begin
        end
      endcase
    end

    // Modifier flags reflect the pressed state after this press took effect.
    flags = {mod_next[4] | mod_next[5], mod_next[2] | mod_next[3],
             mod_next[0] | mod_next[1]};
    ring_ctl.push        = push;
    ring_ctl.entry.word  = {flags, req_r.scan_code};
    ring_ctl.entry.stamp = req_r.now_time;
    key_wr.entry         = entry_next;
    rsp_next.key_pending = ring_pending_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      done          <= 1'b0;
      repeat_enable <= 1'b1;
      mod_pressed   <= '0;
    end else begin
      if (cfg_write) begin
        repeat_enable <= cfg_data;
      end
      done <= exec;
      if (exec) begin
        mod_pressed <= mod_next;
      end
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= req;
    end
    if (exec) begin
      result <= rsp_next;
    end
  end

endmodule
